[design/fnrs_pkg.sv]
// fnrs_pkg: register indexes, reset values and fixed constants of the rumble synth
// also holds the elaboration-time quarter-wave sine generator
// no dependencies
package fnrs_pkg;

	typedef logic [2:0] cfg_index_t;
	localparam int CFG_DATA_W = 32;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	localparam cfg_index_t REG_ATTACK     = 3'd0;
	localparam cfg_index_t REG_RELEASE    = 3'd1;
	localparam cfg_index_t REG_LOWPASS    = 3'd2;
	localparam cfg_index_t REG_NOISE_GAIN = 3'd3;
	localparam cfg_index_t REG_SUB_LEVEL  = 3'd4;
	localparam cfg_index_t REG_PHASE_STEP = 3'd5;
	localparam cfg_index_t REG_NOISE_SEED = 3'd6;

	localparam logic [23:0] RST_ATTACK     = 24'd10872;
	localparam logic [23:0] RST_RELEASE    = 24'd5436;
	localparam logic [15:0] RST_LOWPASS    = 16'd1311;
	localparam logic [12:0] RST_NOISE_GAIN = 13'd2816;
	localparam logic [15:0] RST_SUB_LEVEL  = 16'd19661;
	localparam logic [30:0] RST_PHASE_STEP = 31'd4285228;
	localparam logic [31:0] RST_SEED       = 32'd2463534242;

	// gain is unsigned q0.24, one more bit to hold 1.0 itself
	localparam int GAIN_W = 25;
	localparam logic [GAIN_W-1:0] GAIN_ONE = 25'h1000000;

	// 32000 = 250 * 2^7
	localparam logic [7:0] SCALE_MULT = 8'd250;
	localparam int SCALE_PRESHIFT = 7;
	localparam int SAMPLE_W = 16;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned ONE_Q30 = 64'd1073741824;
	localparam longint unsigned TAYLOR_DIV [1:8] = '{64'd6, 64'd20, 64'd42, 64'd72,
		64'd110, 64'd156, 64'd210, 64'd272};

	// sin(i * pi/2 / 2^tbits) in q30, taylor series to order 17, clamped to [0, 1]
	function automatic logic [31:0] quarter_sine_q30(input int unsigned i,
		input int unsigned tbits);
		longint unsigned x;
		longint unsigned term;
		longint sum;
		int k;
		x = (longint'(i) * HALF_PI_Q30) >> tbits;
		term = x;
		sum = longint'(x);
		for (k = 1; k <= 8; k++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			term = term / TAYLOR_DIV[k];
			if (k[0]) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > longint'(ONE_Q30)) begin
			sum = longint'(ONE_Q30);
		end
		return 32'(sum);
	endfunction

endpackage

[design/filtered_noise_rumble_synth.sv]
// filtered_noise_rumble_synth: xorshift noise, two lowpass poles, sub-bass sine, smoothed gain
// one shared digit-serial multiplier (4 bits of the coefficient per cycle) runs every product
// depends on fnrs_pkg
//
//  channel | signals                                     | moves
//  --------+---------------------------------------------+------------------------------
//  in      | in_valid, in_ready, thrust_active           | one item = one tick
//  out     | out_valid, out_ready, sample_value, clipped | one item = one audio sample
//  cfg     | cfg_write, cfg_index, cfg_data              | register write, no handshake
//
// each item: the accept, then seven products through the shared multiplier, each with
// a setup step, its coefficient digit steps and a write-back step, then the load of
// the result register
// reset loads the register defaults and the seed, and clears poles, phase and gain
// a new item is taken while a finished result still waits; only the result load stalls
module filtered_noise_rumble_synth #(
	parameter int SINE_TABLE_BITS = 10,
	parameter int SIGNAL_FRACTION_BITS = 22
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  fnrs_pkg::cfg_index_t  cfg_index,
	input  fnrs_pkg::cfg_data_t   cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  thrust_active,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [15:0]    sample_value,
	output logic                  clipped
);
	import fnrs_pkg::*;

	localparam int F = SIGNAL_FRACTION_BITS;
	localparam int TB = SINE_TABLE_BITS;
	localparam int QLEN = 1 << TB;
	localparam int SW = F + 2;
	localparam int LW = F + 7;
	localparam int AW = (LW > GAIN_W + 1) ? LW : GAIN_W + 1;
	localparam int ACW = AW + 5;
	localparam int BW = GAIN_W;
	localparam int SCALE_DIGITS = 2;
	localparam int SCALE_POST = F - SCALE_PRESHIFT - 4 * SCALE_DIGITS;
	localparam logic signed [ACW-1:0] ONE_ACC = ACW'(64'sd1 <<< F);
	localparam logic [F:0] ONE_MAG = (F+1)'(64'd1 << F);

	// digit counts and right-shifting digits of each product
	localparam logic [2:0] DIG_16 = 3'd4;
	localparam logic [2:0] DIG_24 = 3'd6;
	localparam logic [2:0] DIG_NGAIN = 3'd4;
	localparam logic [2:0] SH_NGAIN = 3'd2;
	localparam logic [2:0] DIG_GAIN = 3'd7;
	localparam logic [2:0] SH_GAIN = 3'd6;
	localparam logic [2:0] DIG_SCALE = 3'(SCALE_DIGITS);

	typedef logic [F:0] sine_word_t;
	typedef sine_word_t sine_rom_t [QLEN+1];

	typedef enum logic [2:0] {ST_IDLE, ST_SETUP, ST_MUL, ST_WB, ST_FINISH} state_t;
	typedef enum logic [2:0] {
		OP_LP1, OP_LP2, OP_SUB, OP_GAIN, OP_NOISE, OP_LEVEL, OP_SCALE
	} op_t;

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		int unsigned i;
		for (i = 0; i <= QLEN; i++) begin
			rom[i] = sine_word_t'(quarter_sine_q30(i, TB) >> (30 - F));
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

	// xorshift with shifts 13, 17, 5
	function automatic logic [31:0] xorshift32(input logic [31:0] s);
		logic [31:0] v;
		v = s ^ (s << 13);
		v = v ^ (v >> 17);
		v = v ^ (v << 5);
		return v;
	endfunction

	state_t state_q;
	op_t op_q;
	logic [2:0] dcnt_q;

	logic [23:0] attack_q, release_q;
	logic [15:0] lowpass_q, sublevel_q;
	logic [12:0] ngain_q;
	logic [30:0] step_q;

	logic [31:0] noise_state_q;
	logic signed [SW-1:0] p1_q, p2_q;
	logic [31:0] phase_q;
	logic [GAIN_W-1:0] gain_q;

	logic out_valid_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic clipped_q;

	logic thrust_q;
	logic signed [AW-1:0] a_q;
	logic [BW-1:0] b_q;
	logic signed [ACW-1:0] acc_q;
	logic signed [SW-1:0] sub_q;
	logic signed [LW-1:0] nsum_q;
	logic [F:0] mag_q;
	logic neg_q, clip_q;
	logic [SAMPLE_W-2:0] res_q;
	sine_word_t sine_q;

	logic [2:0] n_dig, sh_dig;
	logic signed [AW-1:0] a_init, sine_ext;
	logic [BW-1:0] b_init;
	logic signed [F:0] noise_s;
	logic [F:0] noise_bits;
	logic [GAIN_W-1:0] target;
	logic [23:0] coeff;
	logic [TB-1:0] tidx;
	logic [TB:0] ridx;
	logic [3:0] digit;
	logic signed [ACW-1:0] part, acc_sum, acc_neg, scaled;
	logic load_res;

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign sample_value = sample_q;
	assign clipped = clipped_q;

	// result register takes the new item when it is empty or being drained
	assign load_res = (state_q == ST_FINISH) && (!out_valid_q || out_ready);

	// noise in [-1, 1): top bits of the state with the msb flipped
	assign noise_bits = noise_state_q[31 -: F+1];
	assign noise_s = $signed({~noise_bits[F], noise_bits[F-1:0]});

	assign target = thrust_q ? GAIN_ONE : '0;
	assign coeff = (target > gain_q) ? attack_q : release_q;

	// quadrant bit 0 mirrors the index, bit 1 negates
	assign tidx = phase_q[29 -: TB];
	assign ridx = phase_q[30] ? ((TB+1)'(QLEN) - {1'b0, tidx}) : {1'b0, tidx};
	assign sine_ext = AW'($signed({1'b0, sine_q}));

	always_comb begin
		unique case (op_q) inside
			OP_LP1, OP_LP2, OP_SUB: begin
				n_dig = DIG_16;
				sh_dig = DIG_16;
			end
			OP_GAIN: begin
				n_dig = DIG_24;
				sh_dig = DIG_24;
			end
			OP_NOISE: begin
				n_dig = DIG_NGAIN;
				sh_dig = SH_NGAIN;
			end
			OP_LEVEL: begin
				n_dig = DIG_GAIN;
				sh_dig = SH_GAIN;
			end
			OP_SCALE: begin
				n_dig = DIG_SCALE;
				sh_dig = DIG_SCALE;
			end
			default: begin
				n_dig = DIG_16;
				sh_dig = DIG_16;
			end
		endcase
	end

	always_comb begin
		unique case (op_q)
			OP_LP1: begin
				a_init = AW'(noise_s) - AW'(p1_q);
				b_init = BW'(lowpass_q);
			end
			OP_LP2: begin
				a_init = AW'(p1_q) - AW'(p2_q);
				b_init = BW'(lowpass_q);
			end
			OP_SUB: begin
				a_init = phase_q[31] ? -sine_ext : sine_ext;
				b_init = BW'(sublevel_q);
			end
			OP_GAIN: begin
				a_init = AW'($signed({1'b0, target})) - AW'($signed({1'b0, gain_q}));
				b_init = BW'(coeff);
			end
			OP_NOISE: begin
				a_init = AW'(p2_q);
				b_init = BW'(ngain_q);
			end
			OP_LEVEL: begin
				a_init = AW'(nsum_q);
				b_init = gain_q;
			end
			OP_SCALE: begin
				a_init = AW'($signed({1'b0, mag_q}));
				b_init = BW'(SCALE_MULT);
			end
			default: begin
				a_init = '0;
				b_init = '0;
			end
		endcase
	end

	// one coefficient digit per cycle; arithmetic right shift keeps the floor exact
	assign digit = b_q[3:0];
	assign part = ACW'(a_q) * $signed({1'b0, digit});
	assign acc_sum = acc_q + part;
	assign acc_neg = -acc_q;
	assign scaled = acc_q >>> SCALE_POST;

	always_ff @(posedge clk) begin
		sine_q <= SINE_ROM[ridx];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					thrust_q <= thrust_active;
				end
			end
			ST_SETUP: begin
				a_q <= a_init;
				b_q <= b_init;
				acc_q <= '0;
			end
			ST_MUL: begin
				b_q <= b_q >> 4;
				if (dcnt_q < sh_dig) begin
					acc_q <= acc_sum >>> 4;
				end else begin
					// integer part of the coefficient: weight grows instead
					acc_q <= acc_sum;
					a_q <= a_q <<< 4;
				end
			end
			ST_WB: begin
				case (op_q)
					OP_SUB: sub_q <= SW'(acc_q);
					OP_NOISE: nsum_q <= LW'(acc_q) + LW'(sub_q);
					OP_LEVEL: begin
						neg_q <= acc_q[ACW-1];
						if (acc_q > ONE_ACC || acc_q < -ONE_ACC) begin
							mag_q <= ONE_MAG;
							clip_q <= 1'b1;
						end else begin
							mag_q <= acc_q[ACW-1] ? acc_neg[F:0] : acc_q[F:0];
							clip_q <= 1'b0;
						end
					end
					OP_SCALE: res_q <= scaled[SAMPLE_W-2:0];
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= OP_LP1;
			dcnt_q <= '0;
			attack_q <= RST_ATTACK;
			release_q <= RST_RELEASE;
			lowpass_q <= RST_LOWPASS;
			ngain_q <= RST_NOISE_GAIN;
			sublevel_q <= RST_SUB_LEVEL;
			step_q <= RST_PHASE_STEP;
			noise_state_q <= RST_SEED;
			p1_q <= '0;
			p2_q <= '0;
			phase_q <= '0;
			gain_q <= '0;
			out_valid_q <= 1'b0;
			sample_q <= '0;
			clipped_q <= 1'b0;
		end else begin
			if (load_res) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_write) begin
				unique case (cfg_index)
					REG_ATTACK: attack_q <= cfg_data[23:0];
					REG_RELEASE: release_q <= cfg_data[23:0];
					REG_LOWPASS: lowpass_q <= cfg_data[15:0];
					REG_NOISE_GAIN: ngain_q <= cfg_data[12:0];
					REG_SUB_LEVEL: sublevel_q <= cfg_data[15:0];
					REG_PHASE_STEP: step_q <= cfg_data[30:0];
					REG_NOISE_SEED: noise_state_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						noise_state_q <= xorshift32(noise_state_q);
						phase_q <= phase_q + 32'(step_q);
						op_q <= OP_LP1;
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					dcnt_q <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (dcnt_q == n_dig - 3'd1) begin
						state_q <= ST_WB;
					end else begin
						dcnt_q <= dcnt_q + 3'd1;
					end
				end
				ST_WB: begin
					case (op_q)
						OP_LP1: p1_q <= p1_q + SW'(acc_q);
						OP_LP2: p2_q <= p2_q + SW'(acc_q);
						OP_GAIN: gain_q <= gain_q + GAIN_W'(acc_q);
						default: ;
					endcase
					if (op_q == OP_SCALE) begin
						state_q <= ST_FINISH;
					end else begin
						op_q <= op_t'(3'(op_q + 3'd1));
						state_q <= ST_SETUP;
					end
				end
				ST_FINISH: begin
					if (load_res) begin
						sample_q <= neg_q ? -$signed({1'b0, res_q}) : $signed({1'b0, res_q});
						clipped_q <= clip_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[verif/tb_filtered_noise_rumble_synth.sv]
`timescale 1ns / 100ps
// tb_filtered_noise_rumble_synth: directed table, then randomized ticks checked against an
// in-bench predictor of the noise, lowpass, sine and gain path; depends on fnrs_pkg and the dut
module tb_filtered_noise_rumble_synth;
	import fnrs_pkg::*;

	localparam int TBL_BITS = 10;
	localparam int FRAC = 22;
	localparam longint LEVEL_ONE = 64'sd1 << FRAC;
	localparam longint GAIN_FULL = 64'sd1 << 24;
	localparam cfg_index_t REG_NONE = 3'd7;
	localparam int N_ROWS = 24;
	localparam int N_PHASES = 8;
	localparam int TICKS_PER_PHASE = 100;
	localparam int HOLD_CYCLES = 400;

	typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;
	typedef struct packed {
		row_kind_t kind;
		cfg_index_t idx;
		cfg_data_t data;
		logic thrust;
		logic known;
		logic signed [15:0] smp;
		logic clp;
	} dir_row_t;
	typedef struct packed {
		logic signed [15:0] smp;
		logic clp;
	} audio_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	cfg_index_t cfg_index = '0;
	cfg_data_t cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic thrust_active = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] sample_value;
	logic clipped;

	// predictor registers and state
	logic [23:0] attack_r = RST_ATTACK;
	logic [23:0] release_r = RST_RELEASE;
	logic [15:0] lowpass_r = RST_LOWPASS;
	logic [12:0] ngain_r = RST_NOISE_GAIN;
	logic [15:0] sublvl_r = RST_SUB_LEVEL;
	logic [30:0] step_r = RST_PHASE_STEP;
	logic [31:0] noise_r = RST_SEED;
	longint pole1 = 0;
	longint pole2 = 0;
	logic [31:0] phase_r = '0;
	longint gain_r = 0;
	longint quarter_wave [0:(1 << TBL_BITS)];

	audio_out_t owed_samples [$];
	dir_row_t directed_rows [N_ROWS];
	int error_count = 0;
	int send_gap_pct = 20;
	int recv_stall_pct = 30;
	int holds_asked = 0;

	filtered_noise_rumble_synth u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.thrust_active(thrust_active),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample_value(sample_value),
		.clipped(clipped)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#5000000;
		$display("simulation failed");
		$finish;
	end

	task automatic note_error(input string msg);
		$display("%0t: %s", $time, msg);
		error_count++;
	endtask

	function automatic audio_out_t next_rumble_sample(input logic thr);
		longint noise, sub, target, coeff, lvl, mag, wave;
		int unsigned idx;
		audio_out_t res;
		noise_r = noise_r ^ (noise_r << 13);
		noise_r = noise_r ^ (noise_r >> 17);
		noise_r = noise_r ^ (noise_r << 5);
		noise = longint'(noise_r >> (31 - FRAC)) - LEVEL_ONE;
		// arithmetic shifts floor, as the block does
		pole1 = pole1 + ((longint'(lowpass_r) * (noise - pole1)) >>> 16);
		pole2 = pole2 + ((longint'(lowpass_r) * (pole1 - pole2)) >>> 16);
		phase_r = phase_r + {1'b0, step_r};
		idx = phase_r[29:30-TBL_BITS];
		if (phase_r[30]) begin
			idx = (1 << TBL_BITS) - idx;
		end
		wave = phase_r[31] ? -quarter_wave[idx] : quarter_wave[idx];
		sub = (wave * longint'(sublvl_r)) >>> 16;
		target = thr ? GAIN_FULL : 0;
		coeff = (target > gain_r) ? longint'(attack_r) : longint'(release_r);
		gain_r = gain_r + ((coeff * (target - gain_r)) >>> 24);
		lvl = ((pole2 * longint'(ngain_r)) >>> 8) + sub;
		lvl = (lvl * gain_r) >>> 24;
		res.clp = 1'b0;
		if (lvl > LEVEL_ONE) begin
			lvl = LEVEL_ONE;
			res.clp = 1'b1;
		end else if (lvl < -LEVEL_ONE) begin
			lvl = -LEVEL_ONE;
			res.clp = 1'b1;
		end
		mag = (lvl < 0) ? -lvl : lvl;
		mag = (mag * 32000) >>> FRAC;
		res.smp = 16'((lvl < 0) ? -mag : mag);
		return res;
	endfunction

	function automatic cfg_data_t pick_reg_value();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			default: return $urandom();
		endcase
	endfunction

	task automatic send_tick(input logic thr, input logic known, input audio_out_t typed_res);
		audio_out_t calc;
		cfg_write <= 1'b0;
		if ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < send_gap_pct) @(posedge clk);
		end
		in_valid <= 1'b1;
		thrust_active <= thr;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		calc = next_rumble_sample(thr);
		owed_samples = {owed_samples, known ? typed_res : calc};
	endtask

	// sender stops and waits until every owed sample has come back
	task automatic drain_block();
		in_valid <= 1'b0;
		cfg_write <= 1'b0;
		@(posedge clk);
		while (owed_samples.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input cfg_data_t val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_ATTACK: attack_r = val[23:0];
			REG_RELEASE: release_r = val[23:0];
			REG_LOWPASS: lowpass_r = val[15:0];
			REG_NOISE_GAIN: ngain_r = val[12:0];
			REG_SUB_LEVEL: sublvl_r = val[15:0];
			REG_PHASE_STEP: step_r = val[30:0];
			REG_NOISE_SEED: noise_r = val;
			default: ;
		endcase
	endtask

	initial begin : sample_sink
		int hold_left;
		int holds_done;
		audio_out_t want;
		hold_left = 0;
		holds_done = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (owed_samples.size() == 0) begin
					note_error($sformatf("sample %0d clipped %0b with none owed",
						sample_value, clipped));
				end else begin
					want = owed_samples.pop_front();
					if (sample_value !== want.smp) begin
						note_error($sformatf("sample_value %0d, predicted %0d",
							sample_value, want.smp));
					end
					if (clipped !== want.clp) begin
						note_error($sformatf("clipped %0b, predicted %0b", clipped, want.clp));
					end
				end
			end
			if (holds_done != holds_asked) begin
				holds_done = holds_asked;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	initial begin : tick_source
		longint unsigned x, term;
		longint acc;
		logic run_thr;
		int run_left;
		run_thr = 1'b0;
		run_left = 0;

		// quarter-wave sine by taylor series in q30, kept at signal precision
		for (int i = 0; i <= (1 << TBL_BITS); i++) begin
			x = (64'(i) * HALF_PI_Q30) >> TBL_BITS;
			term = x;
			acc = longint'(x);
			for (int k = 1; k <= 8; k++) begin
				term = (term * x) >> 30;
				term = (term * x) >> 30;
				term = term / (4 * k * k + 2 * k);
				if (k % 2 == 1) begin
					acc = acc - longint'(term);
				end else begin
					acc = acc + longint'(term);
				end
			end
			if (acc < 0) begin
				acc = 0;
			end
			if (acc > longint'(ONE_Q30)) begin
				acc = longint'(ONE_Q30);
			end
			quarter_wave[i] = acc >>> (30 - FRAC);
		end

		// zero seed holds the noise at -1.0, so full gain drives the level hard negative
		directed_rows = '{
			'{ROW_TICK, REG_ATTACK, '0, 1'b0, 1'b1, 16'sd0, 1'b0},
			'{ROW_TICK, REG_ATTACK, '0, 1'b0, 1'b1, 16'sd0, 1'b0},
			'{ROW_TICK, REG_ATTACK, '0, 1'b1, 1'b0, 16'sd0, 1'b0},
			'{ROW_TICK, REG_ATTACK, '0, 1'b1, 1'b0, 16'sd0, 1'b0},
			'{ROW_TICK, REG_ATTACK, '0, 1'b0, 1'b0, 16'sd0, 1'b0},
			'{ROW_WRITE, REG_NONE, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'sd0, 1'b0},
			'{ROW_WRITE, REG_ATTACK, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'sd0, 1'b0},
			'{ROW_WRITE, REG_RELEASE, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'sd0, 1'b0},
			'{ROW_WRITE, REG_LOWPASS, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'sd0, 1'b0},
			'{ROW_WRITE, REG_NOISE_GAIN, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'sd0, 1'b0},
			'{ROW_WRITE, REG_SUB_LEVEL, 32'h0, 1'b0, 1'b0, 16'sd0, 1'b0},
			'{ROW_WRITE, REG_NOISE_SEED, 32'h0, 1'b0, 1'b0, 16'sd0, 1'b0},
			'{ROW_TICK, REG_ATTACK, '0, 1'b1, 1'b1, -16'sd32000, 1'b1},
			'{ROW_TICK, REG_ATTACK, '0, 1'b1, 1'b1, -16'sd32000, 1'b1},
			'{ROW_TICK, REG_ATTACK, '0, 1'b0, 1'b1, 16'sd0, 1'b0},
			'{ROW_WRITE, REG_PHASE_STEP, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'sd0, 1'b0},
			'{ROW_WRITE, REG_SUB_LEVEL, 32'h0000_FFFF, 1'b0, 1'b0, 16'sd0, 1'b0},
			'{ROW_WRITE, REG_NOISE_GAIN, 32'h0, 1'b0, 1'b0, 16'sd0, 1'b0},
			'{ROW_WRITE, REG_NOISE_SEED, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'sd0, 1'b0},
			'{ROW_TICK, REG_ATTACK, '0, 1'b1, 1'b0, 16'sd0, 1'b0},
			'{ROW_TICK, REG_ATTACK, '0, 1'b1, 1'b0, 16'sd0, 1'b0},
			'{ROW_TICK, REG_ATTACK, '0, 1'b0, 1'b1, 16'sd0, 1'b0},
			'{ROW_WRITE, REG_ATTACK, 32'h0, 1'b0, 1'b0, 16'sd0, 1'b0},
			'{ROW_TICK, REG_ATTACK, '0, 1'b1, 1'b1, 16'sd0, 1'b0}
		};

		@(posedge clk);
		while (!arst_n) @(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				if (owed_samples.size() != 0) begin
					drain_block();
				end
				write_reg(directed_rows[i].idx, directed_rows[i].data);
			end else begin
				send_tick(directed_rows[i].thrust, directed_rows[i].known,
					{directed_rows[i].smp, directed_rows[i].clp});
			end
		end

		for (int ph = 0; ph < N_PHASES; ph++) begin
			drain_block();
			send_gap_pct = (ph < 3) ? 9 : (ph < 6) ? 66 : 0;
			recv_stall_pct = (ph < 3) ? 66 : (ph < 6) ? 9 : 0;
			if (ph == 0) begin
				write_reg(REG_ATTACK, RST_ATTACK);
				write_reg(REG_RELEASE, RST_RELEASE);
				write_reg(REG_LOWPASS, RST_LOWPASS);
				write_reg(REG_NOISE_GAIN, RST_NOISE_GAIN);
				write_reg(REG_SUB_LEVEL, RST_SUB_LEVEL);
				write_reg(REG_PHASE_STEP, RST_PHASE_STEP);
				write_reg(REG_NOISE_SEED, RST_SEED);
			end else begin
				for (int r = 0; r <= REG_NONE; r++) begin
					if ($urandom_range(0, 1) == 1) begin
						write_reg(cfg_index_t'(r), pick_reg_value());
					end
				end
			end
			// long receiver stall while ticks keep coming, so the input backs up
			if (ph == 1 || ph == 6) begin
				holds_asked++;
			end
			for (int n = 0; n < TICKS_PER_PHASE; n++) begin
				// mostly long thrust runs so the gain ramps, with short flickers mixed in
				if (run_left == 0) begin
					run_thr = 1'($urandom_range(0, 1));
					run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) :
						$urandom_range(8, 80);
				end
				run_left--;
				send_tick(run_thr, 1'b0, '0);
			end
		end

		drain_block();
		repeat (100) @(posedge clk);
		if (error_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

[sim.f]
design/fnrs_pkg.sv
design/filtered_noise_rumble_synth.sv
verif/tb_filtered_noise_rumble_synth.sv
